FILE: rtl/core/bchd_pkg.sv
// shared types and constants of the button click and hold detector
// no dependencies; imported by every module of the block except bchd_slice
`default_nettype none

package bchd_pkg;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    CFG_DEBOUNCE      = 3'd0,
    CFG_HOLD_TIMEOUT  = 3'd1,
    CFG_CLICK_TIMEOUT = 3'd2,
    CFG_STEP_TIMEOUT  = 3'd3,
    CFG_INVERT_SENSE  = 3'd4,
    CFG_ACTIVE_HIGH   = 3'd5
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CNT_W      = 8;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST      = 16'd60;
  localparam logic [CFG_DATA_W-1:0] HOLD_TIMEOUT_RST  = 16'd500;
  localparam logic [CFG_DATA_W-1:0] CLICK_TIMEOUT_RST = 16'd500;
  localparam logic [CFG_DATA_W-1:0] STEP_TIMEOUT_RST  = 16'd400;

  localparam logic [CNT_W-1:0] CLICKS_MAX = 8'hFF;

  // bit positions in the sticky event flags
  localparam int unsigned EV_PRESS   = 0;
  localparam int unsigned EV_RELEASE = 1;
  localparam int unsigned EV_CLICK   = 2;
  localparam int unsigned EV_HELD    = 3;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce_ms;
    logic [CFG_DATA_W-1:0] hold_timeout_ms;
    logic [CFG_DATA_W-1:0] click_timeout_ms;
    logic [CFG_DATA_W-1:0] step_timeout_ms;
    logic                  invert_sense;
    logic                  active_high;
  } cfg_t;

  // input word, last member sits in the lowest bits
  typedef struct packed {
    logic              clear_all;
    logic [CNT_W-1:0]  step_clicks;
    logic              step_query;
    logic              ack_clicks;
    logic              ack_held;
    logic              ack_click;
    logic              ack_release;
    logic              ack_press;
    logic [TIME_W-1:0] now_ms;
    logic              pin_level;
  } item_t;

  // result word, last member sits in the lowest bits
  typedef struct packed {
    logic             step_fire;
    logic [CNT_W-1:0] hold_click_count;
    logic [CNT_W-1:0] click_count;
    logic             clicks_ready;
    logic             holding;
    logic             held_event;
    logic             click_event;
    logic             release_event;
    logic             press_event;
    logic             is_pressed;
  } res_t;

  localparam int unsigned ITEM_W = $bits(item_t);
  localparam int unsigned RES_W  = $bits(res_t);

  typedef struct packed {
    logic              pressed_latched;
    logic              debounce_running;
    logic [TIME_W-1:0] event_time;
    logic              hold_active;
    logic              step_active;
    logic              click_pending;
    logic [3:0]        sticky;
    logic              series_ready;
    logic              series_clear_pending;
    logic [CNT_W-1:0]  running_clicks;
    logic [CNT_W-1:0]  closed_clicks;
    logic [CNT_W-1:0]  clicks_before_hold;
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/button_click_hold_detector.sv
// Push-button debounce, multi-click and hold detector.
// Each word on the slave stream is one evaluation of the button: raw pin
// level, a millisecond timestamp (differences taken modulo 2^32), event
// acknowledges, a step query and a clear-all flag. Each word gives exactly one
// word on the master stream with the pressed level, sticky event flags, the
// closed click count, the clicks before the latest hold and a step pulse.
// Timeouts and pin sense are set on the write port (index 0 debounce, 1 hold,
// 2 click, 3 step timeout, 4 invert sense, 5 active high); the user must set
// them only while idle, which the block itself does not enforce.
// A word accepted on the slave stream is held in the input register, and its
// result is loaded into the result register, which drives m_axis_tvalid.
// Throughput: one word per cycle while results are taken; the whole update is
// one combinational pass from the state and input registers to the result reg.
// When the receiver stalls the result word holds, the input register fills,
// and s_axis_tready falls only once both are occupied; nothing is lost.
// Reset clears all button state and the stream valids and loads the default
// timeouts (60, 500, 500, 400 ms) with low pin meaning pressed.
// Depends on bchd_pkg, bchd_cfg_regs, bchd_slice and bchd_core.
`default_nettype none

module button_click_hold_detector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bchd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bchd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pin_level, now_ms[32], ack_press, ack_release, ack_click, ack_held,
  // ack_clicks, step_query, step_clicks[8], clear_all
  input  logic [bchd_pkg::ITEM_W-1:0]      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // is_pressed, press_event, release_event, click_event, held_event,
  // holding, clicks_ready, click_count[8], hold_click_count[8], step_fire
  output logic [bchd_pkg::RES_W-1:0]       m_axis_tdata
);
  import bchd_pkg::*;

  cfg_t                cfg;
  logic                in_valid;
  logic                out_ready;
  logic [ITEM_W-1:0]   in_data;
  res_t                res;

  bchd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bchd_slice #(.Width(ITEM_W)) u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata),
    .valid_o (in_valid),
    .ready_i (out_ready),
    .data_o  (in_data)
  );

  bchd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_valid && out_ready),
    .cfg_i  (cfg),
    .item_i (item_t'(in_data)),
    .res_o  (res)
  );

  bchd_slice #(.Width(RES_W)) u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .ready_o (out_ready),
    .data_i  (res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: rtl/core/bchd_cfg_regs.sv
// configuration registers of the button click and hold detector
// depends on bchd_pkg
`default_nettype none

module bchd_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bchd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bchd_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output bchd_pkg::cfg_t                   cfg_o
);
  import bchd_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms      <= DEBOUNCE_RST;
      cfg_q.hold_timeout_ms  <= HOLD_TIMEOUT_RST;
      cfg_q.click_timeout_ms <= CLICK_TIMEOUT_RST;
      cfg_q.step_timeout_ms  <= STEP_TIMEOUT_RST;
      cfg_q.invert_sense     <= 1'b0;
      cfg_q.active_high      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE:      cfg_q.debounce_ms      <= cfg_wdata_i;
        CFG_HOLD_TIMEOUT:  cfg_q.hold_timeout_ms  <= cfg_wdata_i;
        CFG_CLICK_TIMEOUT: cfg_q.click_timeout_ms <= cfg_wdata_i;
        CFG_STEP_TIMEOUT:  cfg_q.step_timeout_ms  <= cfg_wdata_i;
        CFG_INVERT_SENSE:  cfg_q.invert_sense     <= cfg_wdata_i[0];
        CFG_ACTIVE_HIGH:   cfg_q.active_high      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/bchd_slice.sv
// one-word register slice with valid/ready handshake
// depends on nothing; used for the input and the result stage
`default_nettype none

module bchd_slice #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [Width-1:0] data_o
);

  logic             valid_q;
  logic [Width-1:0] data_q;

  // a held word may be replaced in the cycle it is taken
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/bchd_core.sv
// button state registers and the single-pass update for one word
// depends on bchd_pkg
`default_nettype none

module bchd_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  bchd_pkg::cfg_t  cfg_i,
  input  bchd_pkg::item_t item_i,
  output bchd_pkg::res_t  res_o
);
  import bchd_pkg::*;

  state_t state_q, state_d;

  logic              pressed;
  logic [TIME_W-1:0] diff;

  assign pressed = ~item_i.pin_level ^ cfg_i.invert_sense ^ cfg_i.active_high;
  assign diff    = item_i.now_ms - state_q.event_time;

  always_comb begin
    state_t st;
    logic   touched;
    logic   close_el;
    logic   step_el;
    logic   fire;
    st      = state_q;
    touched = 1'b0;
    fire    = 1'b0;

    // press qualification
    if (pressed && !st.pressed_latched) begin
      if (!st.debounce_running) begin
        st.debounce_running = 1'b1;
        st.event_time       = item_i.now_ms;
        touched             = 1'b1;
      end else if (diff >= {16'b0, cfg_i.debounce_ms}) begin
        st.pressed_latched  = 1'b1;
        st.sticky[EV_PRESS] = 1'b1;
        st.click_pending    = 1'b1;
      end
    end else begin
      st.debounce_running = 1'b0;
    end

    // release
    if (!pressed && st.pressed_latched) begin
      st.pressed_latched = 1'b0;
      if (!st.hold_active && st.running_clicks != CLICKS_MAX) begin
        st.running_clicks = st.running_clicks + 8'd1;
      end
      st.hold_active        = 1'b0;
      st.sticky[EV_RELEASE] = 1'b1;
      st.event_time         = item_i.now_ms;
      touched               = 1'b1;
      if (st.step_active) begin
        st.closed_clicks  = '0;
        st.running_clicks = '0;
        st.step_active    = 1'b0;
      end
      if (st.click_pending) begin
        st.click_pending    = 1'b0;
        st.sticky[EV_CLICK] = 1'b1;
      end
    end

    // hold start; event time moves to now on this path
    if (st.pressed_latched && pressed && !st.hold_active &&
        diff >= {16'b0, cfg_i.hold_timeout_ms}) begin
      st.hold_active        = 1'b1;
      st.clicks_before_hold = st.running_clicks;
      st.sticky[EV_HELD]    = 1'b1;
      st.step_active        = 1'b1;
      st.click_pending      = 1'b0;
      st.event_time         = item_i.now_ms;
      touched               = 1'b1;
    end

    // once event time was moved to now the elapsed time is zero
    close_el = touched ? (cfg_i.click_timeout_ms == '0)
                       : (diff >= {16'b0, cfg_i.click_timeout_ms});
    step_el  = touched ? (cfg_i.step_timeout_ms == '0)
                       : (diff >= {16'b0, cfg_i.step_timeout_ms});

    // series close
    if (close_el && st.running_clicks != '0 && !pressed) begin
      st.closed_clicks  = st.running_clicks;
      st.running_clicks = '0;
      st.series_ready   = 1'b1;
    end

    if (st.series_clear_pending) begin
      st.closed_clicks        = '0;
      st.series_ready         = 1'b0;
      st.series_clear_pending = 1'b0;
    end

    if (item_i.step_query && st.running_clicks == item_i.step_clicks &&
        st.step_active && step_el) begin
      st.event_time = item_i.now_ms;
      fire          = 1'b1;
    end

    res_o.is_pressed       = pressed;
    res_o.press_event      = st.sticky[EV_PRESS];
    res_o.release_event    = st.sticky[EV_RELEASE];
    res_o.click_event      = st.sticky[EV_CLICK];
    res_o.held_event       = st.sticky[EV_HELD];
    res_o.holding          = st.step_active;
    res_o.clicks_ready     = st.series_ready;
    res_o.click_count      = st.closed_clicks;
    res_o.hold_click_count = st.clicks_before_hold;
    res_o.step_fire        = fire;

    // acknowledges act after the result
    if (item_i.ack_press)   st.sticky[EV_PRESS]   = 1'b0;
    if (item_i.ack_release) st.sticky[EV_RELEASE] = 1'b0;
    if (item_i.ack_click)   st.sticky[EV_CLICK]   = 1'b0;
    if (item_i.ack_held)    st.sticky[EV_HELD]    = 1'b0;
    if (item_i.ack_clicks)  st.series_clear_pending = 1'b1;

    if (item_i.clear_all) begin
      st.sticky             = '0;
      st.step_active        = 1'b0;
      st.series_ready       = 1'b0;
      st.clicks_before_hold = '0;
      st.closed_clicks      = '0;
    end

    state_d = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  // state only moves when a word is processed
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(state_q))
    else $error("button state changed without a word");

  // a hold can only exist while the press is latched
  a_hold_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.hold_active |-> state_q.pressed_latched)
    else $error("hold active without latched press");

  // clear all leaves no sticky flag and no ready series
  a_clear_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.clear_all |=> state_q.sticky == '0 && !state_q.series_ready)
    else $error("clear all did not clear flags");

endmodule

`default_nettype wire

FILE: bench/bchd_result_checker.sv
// result checker for the button click and hold detector
// watches the register port and both streams, predicts each result word
// and compares it field by field; depends on bchd_pkg only
`default_nettype none

module bchd_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bchd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bchd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [bchd_pkg::ITEM_W-1:0]     s_axis_tdata,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [bchd_pkg::RES_W-1:0]      m_axis_tdata,
  output int unsigned                     errors_o,
  output int unsigned                     pending_o,
  output int unsigned                     checked_o,
  output int unsigned                     pulses_o
);
  import bchd_pkg::*;

  cfg_t   cfg;
  state_t st;
  res_t   due_results[$];

  function automatic logic elapsed_at_least(logic [TIME_W-1:0] now,
                                            logic [CFG_DATA_W-1:0] lim);
    logic [TIME_W-1:0] diff;
    diff = now - st.event_time;
    return diff >= {{(TIME_W-CFG_DATA_W){1'b0}}, lim};
  endfunction

  // one button evaluation: updates the tracked state, returns the result word
  function automatic res_t button_eval(item_t it);
    res_t r;
    logic prs;
    logic fire;
    prs  = ~it.pin_level ^ cfg.invert_sense ^ cfg.active_high;
    fire = 1'b0;

    if (prs && !st.pressed_latched) begin
      if (!st.debounce_running) begin
        st.debounce_running = 1'b1;
        st.event_time       = it.now_ms;
      end else if (elapsed_at_least(it.now_ms, cfg.debounce_ms)) begin
        st.pressed_latched  = 1'b1;
        st.sticky[EV_PRESS] = 1'b1;
        st.click_pending    = 1'b1;
      end
    end else begin
      st.debounce_running = 1'b0;
    end

    if (!prs && st.pressed_latched) begin
      st.pressed_latched = 1'b0;
      if (!st.hold_active && st.running_clicks != CLICKS_MAX)
        st.running_clicks = st.running_clicks + CNT_W'(1);
      st.hold_active        = 1'b0;
      st.sticky[EV_RELEASE] = 1'b1;
      st.event_time         = it.now_ms;
      if (st.step_active) begin
        st.closed_clicks  = '0;
        st.running_clicks = '0;
        st.step_active    = 1'b0;
      end
      if (st.click_pending) begin
        st.click_pending    = 1'b0;
        st.sticky[EV_CLICK] = 1'b1;
      end
    end

    if (st.pressed_latched && prs && !st.hold_active &&
        elapsed_at_least(it.now_ms, cfg.hold_timeout_ms)) begin
      st.hold_active        = 1'b1;
      st.clicks_before_hold = st.running_clicks;
      st.sticky[EV_HELD]    = 1'b1;
      st.step_active        = 1'b1;
      st.click_pending      = 1'b0;
      st.event_time         = it.now_ms;
    end

    if (elapsed_at_least(it.now_ms, cfg.click_timeout_ms) && st.running_clicks != '0 &&
        !prs) begin
      st.closed_clicks  = st.running_clicks;
      st.running_clicks = '0;
      st.series_ready   = 1'b1;
    end

    // a clicks acknowledge from the previous word lands after the close above
    if (st.series_clear_pending) begin
      st.closed_clicks        = '0;
      st.series_ready         = 1'b0;
      st.series_clear_pending = 1'b0;
    end

    if (it.step_query && st.running_clicks == it.step_clicks && st.step_active &&
        elapsed_at_least(it.now_ms, cfg.step_timeout_ms)) begin
      st.event_time = it.now_ms;
      fire          = 1'b1;
    end

    r.is_pressed       = prs;
    r.press_event      = st.sticky[EV_PRESS];
    r.release_event    = st.sticky[EV_RELEASE];
    r.click_event      = st.sticky[EV_CLICK];
    r.held_event       = st.sticky[EV_HELD];
    r.holding          = st.step_active;
    r.clicks_ready     = st.series_ready;
    r.click_count      = st.closed_clicks;
    r.hold_click_count = st.clicks_before_hold;
    r.step_fire        = fire;

    if (it.ack_press)   st.sticky[EV_PRESS]   = 1'b0;
    if (it.ack_release) st.sticky[EV_RELEASE] = 1'b0;
    if (it.ack_click)   st.sticky[EV_CLICK]   = 1'b0;
    if (it.ack_held)    st.sticky[EV_HELD]    = 1'b0;
    if (it.ack_clicks)  st.series_clear_pending = 1'b1;

    if (it.clear_all) begin
      st.sticky             = '0;
      st.step_active        = 1'b0;
      st.series_ready       = 1'b0;
      st.clicks_before_hold = '0;
      st.closed_clicks      = '0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t  got;
    res_t  want;
    string bad;
    if (!rst_ni) begin
      cfg.debounce_ms      = DEBOUNCE_RST;
      cfg.hold_timeout_ms  = HOLD_TIMEOUT_RST;
      cfg.click_timeout_ms = CLICK_TIMEOUT_RST;
      cfg.step_timeout_ms  = STEP_TIMEOUT_RST;
      cfg.invert_sense     = 1'b0;
      cfg.active_high      = 1'b0;
      st                   = '0;
      due_results.delete();
      errors_o  <= 0;
      pending_o <= 0;
      checked_o <= 0;
      pulses_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEBOUNCE:      cfg.debounce_ms      = cfg_wdata_i;
          CFG_HOLD_TIMEOUT:  cfg.hold_timeout_ms  = cfg_wdata_i;
          CFG_CLICK_TIMEOUT: cfg.click_timeout_ms = cfg_wdata_i;
          CFG_STEP_TIMEOUT:  cfg.step_timeout_ms  = cfg_wdata_i;
          CFG_INVERT_SENSE:  cfg.invert_sense     = cfg_wdata_i[0];
          CFG_ACTIVE_HIGH:   cfg.active_high      = cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (due_results.size() == 0) begin
          errors_o <= errors_o + 1;
          if (errors_o < 10)
            $display("unexpected result word %h with nothing outstanding", got);
        end else begin
          want = due_results.pop_front();
          bad  = "";
          if (got.is_pressed !== want.is_pressed)           bad = {bad, " is_pressed"};
          if (got.press_event !== want.press_event)         bad = {bad, " press_event"};
          if (got.release_event !== want.release_event)     bad = {bad, " release_event"};
          if (got.click_event !== want.click_event)         bad = {bad, " click_event"};
          if (got.held_event !== want.held_event)           bad = {bad, " held_event"};
          if (got.holding !== want.holding)                 bad = {bad, " holding"};
          if (got.clicks_ready !== want.clicks_ready)       bad = {bad, " clicks_ready"};
          if (got.click_count !== want.click_count)         bad = {bad, " click_count"};
          if (got.hold_click_count !== want.hold_click_count)
            bad = {bad, " hold_click_count"};
          if (got.step_fire !== want.step_fire)             bad = {bad, " step_fire"};
          if (bad != "") begin
            errors_o <= errors_o + 1;
            if (errors_o < 10)
              $display("result %0d differs in%s: expected %h, got %h",
                       checked_o, bad, want, got);
          end
          if (got.step_fire === 1'b1)
            pulses_o <= pulses_o + 1;
        end
        checked_o <= checked_o + 1;
      end

      if (s_axis_tvalid && s_axis_tready)
        due_results.push_back(button_eval(item_t'(s_axis_tdata)));

      pending_o <= due_results.size();
    end
  end

endmodule

`default_nettype wire

FILE: bench/button_click_hold_detector_tb.sv
// top of the button click and hold detector bench: clock, reset, stimulus
// and verdict; the result checker does the prediction and comparison
// depends on bchd_pkg, bchd_result_checker and the detector rtl
`default_nettype none

module button_click_hold_detector_tb;
  import bchd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES    = 4;
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST  = 3'd7;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ITEM_W-1:0]     s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [RES_W-1:0]      m_axis_tdata;

  int unsigned errors, pending, checked, pulses;
  int unsigned sent      = 0;
  int unsigned settings  = 0;
  int unsigned idle_cycles = 0;
  bit          tx_idle   = 1'b1;
  bit          rx_idle   = 1'b1;
  bit          hold_off_req = 1'b0;
  bit          hold_off_done = 1'b0;

  // stimulus side copy of the settings, only used to shape timestamps and pins
  int unsigned       deb_ms   = 60;
  int unsigned       hold_ms  = 500;
  int unsigned       click_ms = 500;
  int unsigned       step_ms  = 400;
  bit                sense_inv = 1'b0;
  bit                sense_ah  = 1'b0;
  logic [TIME_W-1:0] stamp     = '0;
  logic [CNT_W-1:0]  series_clicks = '0;

  button_click_hold_detector i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bchd_result_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors_o      (errors),
    .pending_o     (pending),
    .checked_o     (checked),
    .pulses_o      (pulses)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned gap;
    wait (rst_ni);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        gap = rx_idle ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_word(input item_t w);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_wr(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(input logic [15:0] deb_v, hold_v, click_v, step_v,
                           input bit inv_v, ah_v);
    settle();
    cfg_wr(CFG_DEBOUNCE, deb_v);
    cfg_wr(CFG_HOLD_TIMEOUT, hold_v);
    cfg_wr(CFG_CLICK_TIMEOUT, click_v);
    cfg_wr(CFG_STEP_TIMEOUT, step_v);
    // upper bits of the one-bit registers must be dropped
    cfg_wr(CFG_INVERT_SENSE, {15'($urandom()), inv_v});
    cfg_wr(CFG_ACTIVE_HIGH, {15'($urandom()), ah_v});
    cfg_wr(CFG_IDX_SPARE, 16'($urandom()));
    cfg_wr(CFG_IDX_LAST, 16'($urandom()));
    cfg_we_i  <= 1'b0;
    deb_ms    = deb_v;
    hold_ms   = hold_v;
    click_ms  = click_v;
    step_ms   = step_v;
    sense_inv = inv_v;
    sense_ah  = ah_v;
    tx_idle   = ($urandom_range(0, 3) != 0);
    rx_idle   = ($urandom_range(0, 3) != 0);
    settings++;
  endtask

  // one evaluation at a given pressed level, random acks and queries
  task automatic send_ev(input bit prs, input int unsigned dt);
    item_t w;
    stamp         = stamp + TIME_W'(dt);
    w.pin_level   = ~prs ^ sense_inv ^ sense_ah;
    w.now_ms      = stamp;
    w.ack_press   = ($urandom_range(0, 3) == 0);
    w.ack_release = ($urandom_range(0, 3) == 0);
    w.ack_click   = ($urandom_range(0, 3) == 0);
    w.ack_held    = ($urandom_range(0, 3) == 0);
    w.ack_clicks  = ($urandom_range(0, 4) == 0);
    w.step_query  = 1'($urandom_range(0, 1));
    w.step_clicks = ($urandom_range(0, 3) != 0) ? series_clicks : CNT_W'($urandom());
    w.clear_all   = ($urandom_range(0, 29) == 0);
    send_word(w);
  endtask

  task automatic dir_ev(input bit prs, input logic [TIME_W-1:0] t, input logic [3:0] evack,
                        input bit ackc, input bit sq, input logic [CNT_W-1:0] sc,
                        input bit clr);
    item_t w;
    stamp         = t;
    w.pin_level   = ~prs ^ sense_inv ^ sense_ah;
    w.now_ms      = t;
    w.ack_press   = evack[EV_PRESS];
    w.ack_release = evack[EV_RELEASE];
    w.ack_click   = evack[EV_CLICK];
    w.ack_held    = evack[EV_HELD];
    w.ack_clicks  = ackc;
    w.step_query  = sq;
    w.step_clicks = sc;
    w.clear_all   = clr;
    send_word(w);
  endtask

  task automatic level_run(input bit prs, input int unsigned dur, input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_ev(prs, $urandom_range(0, 2 * dur / n + 1));
  endtask

  // a click series, maybe ending in a hold with step queries, then quiet
  task automatic gesture();
    int unsigned n_clicks;
    n_clicks      = $urandom_range(0, 3);
    series_clicks = '0;
    for (int unsigned k = 0; k < n_clicks; k++) begin
      level_run(1'b1, deb_ms + $urandom_range(0, hold_ms / 2 + 1), 3);
      level_run(1'b0, $urandom_range(0, click_ms / 2 + 1), 2);
      series_clicks = series_clicks + CNT_W'(1);
    end
    if ($urandom_range(0, 2) == 0)
      level_run(1'b1, deb_ms + hold_ms + $urandom_range(0, 4 * step_ms + 4), 8);
    level_run(1'b0, $urandom_range(0, 1) ? click_ms / 2 : 2 * click_ms + 2, 2);
  endtask

  task automatic noise(input int unsigned cnt);
    item_t w;
    for (int unsigned i = 0; i < cnt; i++) begin
      w = item_t'(ITEM_W'({$urandom(), $urandom()}));
      if ($urandom_range(0, 3) != 0) begin
        stamp    = stamp + TIME_W'($urandom_range(0, 2 * click_ms + 2));
        w.now_ms = stamp;
      end else begin
        stamp = w.now_ms;
      end
      send_word(w);
    end
  endtask

  task automatic burst(input int unsigned n);
    int unsigned target;
    target = sent + n;
    while (sent < target) begin
      if ($urandom_range(0, 9) < 7)
        gesture();
      else
        noise($urandom_range(1, 4));
    end
  endtask

  initial begin : stimulus
    wait (rst_ni);
    @(posedge clk_i);

    // directed, reset settings: debounce 60, hold 500, click 500, step 400
    dir_ev(1'b0, 32'd0, 4'h0, 1'b0, 1'b0, 8'd0, 1'b0);
    dir_ev(1'b1, 32'd10, 4'h0, 1'b0, 1'b0, 8'd0, 1'b0);
    dir_ev(1'b1, 32'd69, 4'h0, 1'b0, 1'b0, 8'd0, 1'b0);
    dir_ev(1'b1, 32'd70, 4'h0, 1'b0, 1'b0, 8'd0, 1'b0);      // debounce just met
    dir_ev(1'b0, 32'd100, 4'h0, 1'b0, 1'b0, 8'd0, 1'b0);
    dir_ev(1'b0, 32'd599, 4'h0, 1'b0, 1'b0, 8'd0, 1'b0);
    dir_ev(1'b0, 32'd600, 4'h0, 1'b0, 1'b0, 8'd0, 1'b0);     // series closes
    dir_ev(1'b0, 32'd610, 4'hF, 1'b1, 1'b0, 8'd0, 1'b0);
    dir_ev(1'b0, 32'd620, 4'h0, 1'b0, 1'b0, 8'd0, 1'b0);     // deferred clicks clear
    dir_ev(1'b1, 32'd700, 4'h0, 1'b0, 1'b0, 8'd0, 1'b0);
    dir_ev(1'b1, 32'd760, 4'h0, 1'b0, 1'b0, 8'd0, 1'b0);
    dir_ev(1'b1, 32'd1200, 4'h0, 1'b0, 1'b1, 8'd0, 1'b0);    // hold starts
    dir_ev(1'b1, 32'd1600, 4'h0, 1'b0, 1'b1, 8'd0, 1'b0);    // step pulse
    dir_ev(1'b1, 32'd1700, 4'h0, 1'b0, 1'b1, 8'd0, 1'b0);
    dir_ev(1'b1, 32'd2000, 4'h0, 1'b0, 1'b1, 8'd255, 1'b0);  // click count mismatch
    dir_ev(1'b0, 32'd2100, 4'h0, 1'b0, 1'b0, 8'd0, 1'b0);
    dir_ev(1'b0, 32'hFFFF_FFFF, 4'hF, 1'b1, 1'b1, 8'd255, 1'b1);
    dir_ev(1'b1, 32'hFFFF_FFF0, 4'h0, 1'b0, 1'b0, 8'd0, 1'b0);
    dir_ev(1'b1, 32'h0000_002C, 4'h0, 1'b0, 1'b0, 8'd0, 1'b0); // across the wrap
    dir_ev(1'b0, 32'd5, 4'h0, 1'b0, 1'b0, 8'd0, 1'b0);          // time goes backwards
    dir_ev(1'b1, 32'd0, 4'h0, 1'b0, 1'b0, 8'd0, 1'b0);
    dir_ev(1'b0, 32'h0000_2000, 4'h0, 1'b0, 1'b1, 8'd0, 1'b0);

    apply_cfg(16'd5, 16'd40, 16'd30, 16'd10, 1'b0, 1'b0);
    hold_off_req = 1'b1;
    tx_idle      = 1'b0;
    burst(120);

    apply_cfg(16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
    burst(60);

    apply_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
    burst(100);

    apply_cfg(16'd3, 16'd25, 16'd20, 16'd0, 1'b1, 1'b1);
    burst(100);

    repeat (2) begin
      apply_cfg(16'($urandom_range(0, 60)), 16'($urandom_range(0, 120)),
                16'($urandom_range(0, 90)), 16'($urandom_range(0, 40)),
                1'($urandom()), 1'($urandom()));
      burst(80);
    end

    settle();
    $display("covered %0d button words under %0d register settings", sent, settings);
    $display("%0d results checked, %0d step pulses, %0d mismatches", checked, pulses, errors);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
